// ===== hdl/vcsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the vector configuration and CSR unit.
package vcsr_pkg;

    // Operation of one request
    typedef enum logic [1:0] {
        OP_CSR      = 2'd0,
        OP_VSETVLI  = 2'd1,
        OP_VSETIVLI = 2'd2,
        OP_VSETVL   = 2'd3
    } op_t;

    // CSR access kind; the fourth code reads without writing
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } csr_kind_t;

    localparam int unsigned CSR_ADDR_W = 12;
    localparam int unsigned GENERIC_CSR_ENTRIES = 4096;
    localparam int unsigned STORE_IDX_W = $clog2(GENERIC_CSR_ENTRIES);

    localparam logic [CSR_ADDR_W-1:0] CSR_VSTART  = 12'h008;
    localparam logic [CSR_ADDR_W-1:0] CSR_VXSAT   = 12'h009;
    localparam logic [CSR_ADDR_W-1:0] CSR_VXRM    = 12'h00a;
    localparam logic [CSR_ADDR_W-1:0] CSR_VCSR    = 12'h00f;
    localparam logic [CSR_ADDR_W-1:0] CSR_CYCLE   = 12'hc00;
    localparam logic [CSR_ADDR_W-1:0] CSR_INSTRET = 12'hc02;
    localparam logic [CSR_ADDR_W-1:0] CSR_VL      = 12'hc20;
    localparam logic [CSR_ADDR_W-1:0] CSR_VTYPE   = 12'hc21;
    localparam logic [CSR_ADDR_W-1:0] CSR_VLENB   = 12'hc22;
    localparam logic [CSR_ADDR_W-1:0] CSR_MHARTID = 12'hf14;

    localparam logic [63:0] VILL_MARK = 64'h8000_0000_0000_0000;
    localparam int unsigned HART_ID_W = 10;

    typedef struct packed {
        op_t                   op;
        csr_kind_t             csr_kind;
        logic [CSR_ADDR_W-1:0] csr_address;
        logic [63:0]           source_value;
        logic                  source_is_zero_reg;
        logic                  dest_is_zero_reg;
        logic [63:0]           vtype_request;
        logic [63:0]           cycle_count;
        logic [63:0]           retired_count;
    } req_t;

    typedef struct packed {
        logic [63:0] rd_value;
        logic [7:0]  vl_now;
        logic        vtype_illegal;
    } rsp_t;

    // Kept vector CSR state other than vl
    typedef struct packed {
        logic [31:0] vstart;
        logic [2:0]  vcsr;
        logic        vill;
        logic [7:0]  vtype;
    } vstate_t;

    // Write request into the generic CSR store
    typedef struct packed {
        logic                   en;
        logic [STORE_IDX_W-1:0] addr;
        logic [63:0]            data;
    } store_wr_t;

endpackage

// ===== hdl/vcsr_store.sv =====
`timescale 1ns / 1ps
// Generic CSR store: 4096 x 64 memory with a clearing sweep after reset.
module vcsr_store
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [vcsr_pkg::STORE_IDX_W-1:0] rd_addr,
    output logic [63:0]                     rd_data,
    input  vcsr_pkg::store_wr_t             wr,
    output logic                            busy
);
    import vcsr_pkg::*;

    logic [63:0]            mem_reg [GENERIC_CSR_ENTRIES];
    logic [63:0]            rd_data_reg;
    logic [STORE_IDX_W-1:0] clr_idx_reg;
    logic [STORE_IDX_W-1:0] clr_idx_next;
    logic                   busy_reg;
    logic                   busy_next;

    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == STORE_IDX_W'(GENERIC_CSR_ENTRIES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    // Sweep zeros while busy, else take the execute write
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem_reg[clr_idx_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== hdl/vcsr_exec.sv =====
`timescale 1ns / 1ps
// Execute logic: CSR read-modify-write and vsetvl evaluation for one request.
module vcsr_exec
#(
    parameter int unsigned VECTOR_LENGTH_BITS = 128,
    parameter int unsigned VL_W = 8
)
(
    input  vcsr_pkg::req_t                     req,
    input  vcsr_pkg::vstate_t                  state,
    input  logic [VL_W-1:0]                    vl,
    input  logic [vcsr_pkg::HART_ID_W-1:0]     hart_id,
    input  logic [63:0]                        store_old,
    output vcsr_pkg::vstate_t                  state_next,
    output logic [VL_W-1:0]                    vl_next,
    output vcsr_pkg::store_wr_t                wr,
    output vcsr_pkg::rsp_t                     rsp
);
    import vcsr_pkg::*;

    localparam logic [63:0] VLENB = 64'(VECTOR_LENGTH_BITS / 8);

    logic [63:0]     old_val;
    logic [63:0]     new_val;
    logic            do_write;
    logic [63:0]     avl;
    logic [2:0]      lmul;
    logic [2:0]      sew;
    logic            bad;
    logic [63:0]     vlmax_wide;
    logic [VL_W-1:0] vlmax;
    logic [63:0]     vl_ext;

    always_comb
    begin
        unique case (req.csr_address)
            CSR_VSTART:  old_val = 64'(state.vstart);
            CSR_VXSAT:   old_val = 64'(state.vcsr[0]);
            CSR_VXRM:    old_val = 64'(state.vcsr[2:1]);
            CSR_VCSR:    old_val = 64'(state.vcsr);
            CSR_VL:      old_val = 64'(vl);
            CSR_VTYPE:   old_val = state.vill ? VILL_MARK : 64'(state.vtype);
            CSR_VLENB:   old_val = VLENB;
            CSR_CYCLE:   old_val = req.cycle_count;
            CSR_INSTRET: old_val = req.retired_count;
            CSR_MHARTID: old_val = 64'(hart_id);
            default:     old_val = store_old;
        endcase
    end

    always_comb
    begin
        unique case (req.csr_kind)
            KIND_WRITE:
            begin
                new_val  = req.source_value;
                do_write = 1'b1;
            end
            KIND_SET:
            begin
                new_val  = old_val | req.source_value;
                do_write = (req.source_value != '0);
            end
            KIND_CLEAR:
            begin
                new_val  = old_val & ~req.source_value;
                do_write = (req.source_value != '0);
            end
            KIND_READ:
            begin
                new_val  = old_val;
                do_write = 1'b0;
            end
        endcase
    end

    // vsetvl: AVL choice, vtype legality and VLMAX clamp
    always_comb
    begin
        lmul = req.vtype_request[2:0];
        sew  = req.vtype_request[5:3];
        bad  = (req.vtype_request[63:8] != '0) || (lmul > 3'd3) || (sew > 3'd3);
        priority if (req.op == OP_VSETIVLI || !req.source_is_zero_reg)
            avl = req.source_value;
        else if (!req.dest_is_zero_reg)
            avl = '1;
        else
            avl = 64'(vl);
        vlmax_wide = (VLENB >> sew[1:0]) << lmul[1:0];
        vlmax      = vlmax_wide[VL_W-1:0];
    end

    always_comb
    begin
        state_next = state;
        vl_next    = vl;
        wr.en      = 1'b0;
        wr.addr    = req.csr_address[STORE_IDX_W-1:0];
        wr.data    = new_val;
        if (req.op == OP_CSR)
        begin
            if (do_write)
            begin
                unique case (req.csr_address)
                    CSR_VSTART: state_next.vstart = new_val[31:0];
                    CSR_VXSAT:  state_next.vcsr   = {state.vcsr[2:1], new_val[0]};
                    CSR_VXRM:   state_next.vcsr   = {new_val[1:0], state.vcsr[0]};
                    CSR_VCSR:   state_next.vcsr   = new_val[2:0];
                    CSR_VL, CSR_VTYPE, CSR_VLENB, CSR_CYCLE, CSR_INSTRET, CSR_MHARTID:
                    begin
                        // read-only: drop the write
                    end
                    default:    wr.en = 1'b1;
                endcase
            end
        end
        else
        begin
            state_next.vstart = '0;
            if (bad)
            begin
                state_next.vill  = 1'b1;
                state_next.vtype = '0;
                vl_next          = '0;
            end
            else
            begin
                state_next.vill  = 1'b0;
                state_next.vtype = req.vtype_request[7:0];
                vl_next          = (avl < vlmax_wide) ? avl[VL_W-1:0] : vlmax;
            end
        end
    end

    always_comb
    begin
        vl_ext            = 64'(vl_next);
        rsp.rd_value      = (req.op == OP_CSR) ? old_val : vl_ext;
        rsp.vl_now        = vl_ext[7:0];
        rsp.vtype_illegal = state_next.vill;
    end

endmodule

// ===== hdl/vector_config_and_csr_unit.sv =====
`timescale 1ns / 1ps
// Top level of the vector configuration and CSR unit.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one CSR access or
//   vsetvli / vsetivli / vsetvl per transaction; rsp channel (rsp_valid /
//   rsp_stall / rsp_data) returns exactly one result per request, in order:
//   the old CSR value (or the new vl), vl after the request and vill.
//   cfg_write / cfg_data load the hart id returned by mhartid; write it only
//   while no request is in flight.
// Timing:
//   A request accepted into the request register is evaluated by the execute
//   logic and its result is held in the result register, from which it is
//   offered on rsp. Throughput is one transaction per cycle while rsp_stall
//   is low, set by a single pass through the execute logic between the
//   request register and the result register; the generic CSR store is read as
//   the request is accepted and written as it leaves.
// Reset:
//   Vector state and the hart id clear at once; the 4096-entry generic CSR
//   store is then swept to zero, one entry per cycle, with req_stall held
//   high throughout.
// Back-pressure:
//   A stalled result holds in the result register; the request register
//   fills behind it and only then does req_stall rise.
module vector_config_and_csr_unit
#(
    parameter int unsigned VECTOR_LENGTH_BITS = 128
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  vcsr_pkg::req_t                req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output vcsr_pkg::rsp_t                rsp_data,
    input  logic                          cfg_write,
    input  logic [vcsr_pkg::HART_ID_W-1:0] cfg_data
);
    import vcsr_pkg::*;

    // vl can reach VLMAX at the widest group, i.e. VECTOR_LENGTH_BITS itself
    localparam int unsigned VL_W = $clog2(VECTOR_LENGTH_BITS + 1);

    // Handshake
    logic req_accept;
    logic s1_fire;
    logic store_busy;

    // Request register and result register
    req_t s1_req_reg;
    logic s1_valid_reg;
    logic s1_valid_next;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    // Architectural state
    vstate_t               vstate_reg;
    vstate_t               vstate_next;
    logic [VL_W-1:0]       vl_reg;
    logic [VL_W-1:0]       vl_next;
    logic [HART_ID_W-1:0]  hart_id_reg;

    // Store access and write-to-read forwarding
    logic [63:0] store_rd_data;
    store_wr_t   store_wr;
    store_wr_t   store_wr_fire;
    logic        fwd_valid_reg;
    logic [63:0] fwd_data_reg;
    logic        fwd_hit;
    logic [63:0] store_old;
    rsp_t        exec_rsp;

    // Advance the request register when the result register is free or draining
    assign s1_fire    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = store_busy || (s1_valid_reg && !s1_fire);
    assign req_accept = req_valid && !req_stall;

    // Commit the store write only as the request leaves the request register
    always_comb
    begin
        store_wr_fire    = store_wr;
        store_wr_fire.en = store_wr.en && s1_fire;
    end

    // A write leaving now to the address being read now: the memory returns
    // stale data, so capture the written value instead
    assign fwd_hit   = store_wr_fire.en
                       && (store_wr.addr == req_data.csr_address[STORE_IDX_W-1:0]);
    assign store_old = fwd_valid_reg ? fwd_data_reg : store_rd_data;

    vcsr_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (req_accept),
        .rd_addr (req_data.csr_address[STORE_IDX_W-1:0]),
        .rd_data (store_rd_data),
        .wr      (store_wr_fire),
        .busy    (store_busy)
    );

    vcsr_exec
    #(
        .VECTOR_LENGTH_BITS (VECTOR_LENGTH_BITS),
        .VL_W               (VL_W)
    )
    u_exec
    (
        .req        (s1_req_reg),
        .state      (vstate_reg),
        .vl         (vl_reg),
        .hart_id    (hart_id_reg),
        .store_old  (store_old),
        .state_next (vstate_next),
        .vl_next    (vl_next),
        .wr         (store_wr),
        .rsp        (exec_rsp)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (s1_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            vstate_reg    <= '0;
            vl_reg        <= '0;
            hart_id_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (s1_fire)
            begin
                vstate_reg <= vstate_next;
                vl_reg     <= vl_next;
            end
            if (cfg_write)
            begin
                hart_id_reg <= cfg_data;
            end
            if (req_accept)
            begin
                fwd_valid_reg <= fwd_hit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_req_reg   <= req_data;
            fwd_data_reg <= store_wr.data;
        end
        if (s1_fire)
        begin
            rsp_reg <= exec_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // No request enters while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) store_busy |-> req_stall)
        else $error("request accepted during store clearing sweep");

    // vl never exceeds VLMAX at the widest group
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(vl_reg) <= VECTOR_LENGTH_BITS)
        else $error("vl beyond the largest VLMAX");

    // An illegal vtype always leaves vl at zero
    assert property (@(posedge clk) disable iff (!rst_n) vstate_reg.vill |-> (vl_reg == '0))
        else $error("vill set with non-zero vl");

    // A request leaving the request register is offered as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n) s1_fire |=> rsp_valid)
        else $error("evaluated request did not reach the result register");

endmodule

// ===== tb/tb_vector_config_and_csr_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the vector configuration and CSR unit.
module tb_vector_config_and_csr_unit;

    import vcsr_pkg::*;

    localparam int unsigned VLEN_BITS = 128;
    localparam int unsigned VLENB     = VLEN_BITS / 8;

    // Receiver stall patterns; the monitor switches between them at random
    typedef enum logic [1:0] {
        STALL_NONE   = 2'd0,
        STALL_RANDOM = 2'd1,
        STALL_TOGGLE = 2'd2,
        STALL_RUNS   = 2'd3
    } stall_mode_t;

    // One request waiting for the driver; hold makes it wait until the unit is empty
    typedef struct {
        req_t data;
        bit   hold;
    } queued_req_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req_data  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp_data;
    logic                 cfg_write = 1'b0;
    logic [HART_ID_W-1:0] cfg_data  = '0;

    vector_config_and_csr_unit #(
        .VECTOR_LENGTH_BITS (VLEN_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predicted architectural state of the unit
    // ------------------------------------------------------------------
    logic [HART_ID_W-1:0] hart_id_s = '0;
    logic [31:0]          vstart_s  = '0;
    logic [2:0]           vcsr_s    = '0;   // bit 0 vxsat, bits 2:1 vxrm
    logic [7:0]           vl_s      = '0;
    logic [7:0]           vtype_s   = '0;
    logic                 vill_s    = 1'b0;
    logic [63:0]          store_s [GENERIC_CSR_ENTRIES];

    queued_req_t queued_requests[$];   // filled by the sequence, drained by the driver
    rsp_t        due_responses[$];     // predicted responses, oldest first
    int          in_flight   = 0;      // accepted requests whose response has not been taken
    int          fail_count  = 0;

    int          burst_left  = 0;
    int          gap_left    = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          stall_run   = 0;
    rsp_t        want;

    initial
    begin
        for (int i = 0; i < GENERIC_CSR_ENTRIES; i++)
            store_s[i] = '0;
    end

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run, clearing sweep included
    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] csr_value(logic [CSR_ADDR_W-1:0] addr,
                                              logic [63:0] cyc, logic [63:0] ret);
        case (addr)
            CSR_VSTART:  return {32'd0, vstart_s};
            CSR_VXSAT:   return {63'd0, vcsr_s[0]};
            CSR_VXRM:    return {62'd0, vcsr_s[2:1]};
            CSR_VCSR:    return {61'd0, vcsr_s};
            CSR_VL:      return {56'd0, vl_s};
            CSR_VTYPE:   return vill_s ? VILL_MARK : {56'd0, vtype_s};
            CSR_VLENB:   return 64'(VLENB);
            CSR_CYCLE:   return cyc;
            CSR_INSTRET: return ret;
            CSR_MHARTID: return {54'd0, hart_id_s};
            default:     return store_s[addr];
        endcase
    endfunction

    function automatic void csr_update(logic [CSR_ADDR_W-1:0] addr, logic [63:0] v);
        case (addr)
            CSR_VSTART: vstart_s = v[31:0];
            CSR_VXSAT:  vcsr_s[0] = v[0];
            CSR_VXRM:   vcsr_s[2:1] = v[1:0];
            CSR_VCSR:   vcsr_s = v[2:0];
            // read-only: vl, vtype, vlenb, counters and hart id ignore writes
            CSR_VL, CSR_VTYPE, CSR_VLENB, CSR_CYCLE, CSR_INSTRET, CSR_MHARTID: ;
            default:    store_s[addr] = v;
        endcase
    endfunction

    // Execute one request on the predicted state and return its response
    function automatic rsp_t execute_request(req_t r);
        logic [63:0] prev_val;
        logic [63:0] avl;
        logic [63:0] vlmax;
        logic [2:0]  lmul;
        logic [2:0]  sew;
        logic        bad;
        rsp_t        res;
        if (r.op == OP_CSR)
        begin
            prev_val = csr_value(r.csr_address, r.cycle_count, r.retired_count);
            if (r.csr_kind == KIND_WRITE)
                csr_update(r.csr_address, r.source_value);
            else if (r.csr_kind == KIND_SET && r.source_value != 64'd0)
                csr_update(r.csr_address, prev_val | r.source_value);
            else if (r.csr_kind == KIND_CLEAR && r.source_value != 64'd0)
                csr_update(r.csr_address, prev_val & ~r.source_value);
            res.rd_value = prev_val;
        end
        else
        begin
            lmul = r.vtype_request[2:0];
            sew  = r.vtype_request[5:3];
            bad  = (|r.vtype_request[63:8]) || lmul > 3'd3 || sew > 3'd3;
            if (r.op == OP_VSETIVLI || !r.source_is_zero_reg)
                avl = r.source_value;
            else if (!r.dest_is_zero_reg)
                avl = '1;
            else
                avl = {56'd0, vl_s};
            vstart_s = '0;
            if (bad)
            begin
                // vtype and vl both clear to zero on vill
                vill_s  = 1'b1;
                vtype_s = '0;
                vl_s    = '0;
            end
            else
            begin
                vlmax   = (64'(VLENB) >> sew) << lmul;
                vill_s  = 1'b0;
                vtype_s = r.vtype_request[7:0];
                vl_s    = 8'(avl < vlmax ? avl : vlmax);
            end
            res.rd_value = {56'd0, vl_s};
        end
        res.vl_now        = vl_s;
        res.vtype_illegal = vill_s;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting; print only the first few dozen, count them all
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        if (fail_count < 40)
            $display("%0t mismatch: %s got %h want %h", $time, what, got, exp_val);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Operand biased towards zero, all ones and values near the vl limits
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'($urandom_range(0, 200));
            3:       return 64'($urandom_range(126, 130));
            default: return rand64();
        endcase
    endfunction

    function automatic req_t csr_access(csr_kind_t kind, logic [CSR_ADDR_W-1:0] addr,
                                        logic [63:0] src);
        req_t r;
        r.op                 = OP_CSR;
        r.csr_kind           = kind;
        r.csr_address        = addr;
        r.source_value       = src;
        r.source_is_zero_reg = 1'($urandom_range(0, 1));
        r.dest_is_zero_reg   = 1'($urandom_range(0, 1));
        r.vtype_request      = rand64();
        r.cycle_count        = rand64();
        r.retired_count      = rand64();
        return r;
    endfunction

    function automatic req_t vset(op_t op, logic [63:0] avl, logic rs1_zero, logic rd_zero,
                                  logic [63:0] vt);
        req_t r;
        r.op                 = op;
        r.csr_kind           = csr_kind_t'($urandom_range(0, 3));
        r.csr_address        = 12'($urandom_range(0, 4095));
        r.source_value       = avl;
        r.source_is_zero_reg = rs1_zero;
        r.dest_is_zero_reg   = rd_zero;
        r.vtype_request      = vt;
        r.cycle_count        = rand64();
        r.retired_count      = rand64();
        return r;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r = vset(op_t'($urandom_range(0, 3)), rand64(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), rand64());
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            // CSR access, weighted towards the vector and read-only CSRs
            r.op           = OP_CSR;
            r.source_value = pick_operand();
            case ($urandom_range(0, 3))
                0:
                begin
                    case ($urandom_range(0, 9))
                        0:       r.csr_address = CSR_VSTART;
                        1:       r.csr_address = CSR_VXSAT;
                        2:       r.csr_address = CSR_VXRM;
                        3:       r.csr_address = CSR_VCSR;
                        4:       r.csr_address = CSR_CYCLE;
                        5:       r.csr_address = CSR_INSTRET;
                        6:       r.csr_address = CSR_VL;
                        7:       r.csr_address = CSR_VTYPE;
                        8:       r.csr_address = CSR_VLENB;
                        default: r.csr_address = CSR_MHARTID;
                    endcase
                end
                1:       r.csr_address = 12'h340 + 12'($urandom_range(0, 7));
                default: ;
            endcase
        end
        else if (pick < 90)
        begin
            // vsetvl forms, mostly with a legal vtype
            r.op           = op_t'($urandom_range(1, 3));
            r.source_value = pick_operand();
            case ($urandom_range(0, 9))
                0:       r.vtype_request = rand64() | (64'd1 << $urandom_range(8, 63));
                1:       r.vtype_request = {58'd0, 3'($urandom_range(0, 7)),
                                            3'($urandom_range(4, 7))};
                2:       r.vtype_request = {58'd0, 3'($urandom_range(4, 7)),
                                            3'($urandom_range(0, 7))};
                default: r.vtype_request = {56'd0, 2'($urandom_range(0, 3)),
                                            3'($urandom_range(0, 3)),
                                            3'($urandom_range(0, 3))};
            endcase
        end
        // otherwise keep every field fully random
        return r;
    endfunction

    task automatic queue_request(req_t r, bit hold);
        queued_req_t q;
        q.data = r;
        q.hold = hold;
        queued_requests.insert(queued_requests.size(), q);
    endtask

    // Wait until every queued request has gone and every response has been taken
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || req_valid || in_flight != 0);
        repeat (4) @(negedge clk);
    endtask

    // Write the hart id while the unit is empty; track it in the predictor
    task automatic write_hart_id(logic [HART_ID_W-1:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        hart_id_s  = v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued requests in bursts with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            in_flight  = 0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // track outstanding responses here so the hold decision is race free
            if (rsp_valid && !rsp_stall)
                in_flight = in_flight - 1;
            if (req_valid && !req_stall)
            begin
                due_responses.insert(due_responses.size(), execute_request(req_data));
                in_flight = in_flight + 1;
            end
            // only advance once the current transaction has gone; a stalled one holds
            if (!req_valid || !req_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left  = gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0 &&
                         (!queued_requests[0].hold || in_flight == 0))
                begin
                    req_data  <= queued_requests[0].data;
                    req_valid <= 1'b1;
                    queued_requests.delete(0);
                    if (burst_left <= 1)
                    begin
                        // end of burst: pick the next burst and the gap before it
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken response and drive the stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            mode_left  = 0;
            stall_run  = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_responses.size() == 0)
                    report_mismatch("response with nothing outstanding, rd_value",
                                    rsp_data.rd_value, '0);
                else
                begin
                    want = due_responses[0];
                    due_responses.delete(0);
                    if (rsp_data.rd_value !== want.rd_value)
                        report_mismatch("rd_value", rsp_data.rd_value, want.rd_value);
                    if (rsp_data.vl_now !== want.vl_now)
                        report_mismatch("vl_now", 64'(rsp_data.vl_now), 64'(want.vl_now));
                    if (rsp_data.vtype_illegal !== want.vtype_illegal)
                        report_mismatch("vtype_illegal", 64'(rsp_data.vtype_illegal),
                                        64'(want.vtype_illegal));
                end
            end

            // switch pattern when the mode counter runs out
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(40, 160);
            end
            else
                mode_left = mode_left - 1;

            case (stall_mode)
                STALL_NONE:   rsp_stall <= 1'b0;
                STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
                STALL_TOGGLE: rsp_stall <= ~rsp_stall;
                default:
                begin
                    if (stall_run != 0)
                    begin
                        stall_run  = stall_run - 1;
                        rsp_stall <= 1'b1;
                    end
                    else
                    begin
                        rsp_stall <= 1'b0;
                        if ($urandom_range(0, 5) == 0)
                            stall_run = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [HART_ID_W-1:0] hart_ids [4];
        hart_ids[0] = '1;
        hart_ids[1] = '0;
        hart_ids[2] = HART_ID_W'($urandom_range(1, 1022));
        hart_ids[3] = 10'h155;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // hold off until the clearing sweep of the generic store has finished
        repeat (2) @(negedge clk);
        while (req_stall)
            @(negedge clk);

        // Directed: hart id at its reset value
        queue_request(csr_access(KIND_READ, CSR_MHARTID, rand64()), 1'b0);
        // generic store at both address extremes
        queue_request(csr_access(KIND_WRITE, 12'h000, '1), 1'b0);
        queue_request(csr_access(KIND_READ, 12'h000, '0), 1'b0);
        queue_request(csr_access(KIND_WRITE, 12'hfff, '0), 1'b0);
        // set and clear with zero source must not write
        queue_request(csr_access(KIND_SET, 12'hfff, '0), 1'b0);
        queue_request(csr_access(KIND_SET, 12'hfff, 64'h8000_0000_0000_0001), 1'b0);
        queue_request(csr_access(KIND_CLEAR, 12'hfff, '0), 1'b0);
        queue_request(csr_access(KIND_CLEAR, 12'hfff, 64'h1), 1'b0);
        queue_request(csr_access(KIND_READ, 12'hfff, '1), 1'b0);
        // vstart and the vxsat / vxrm / vcsr aliases
        queue_request(csr_access(KIND_WRITE, CSR_VSTART, '1), 1'b0);
        queue_request(csr_access(KIND_WRITE, CSR_VCSR, '1), 1'b0);
        queue_request(csr_access(KIND_CLEAR, CSR_VXSAT, 64'h1), 1'b0);
        queue_request(csr_access(KIND_WRITE, CSR_VXRM, '0), 1'b0);
        queue_request(csr_access(KIND_READ, CSR_VCSR, '0), 1'b0);
        // read-only CSRs ignore writes
        queue_request(csr_access(KIND_WRITE, CSR_VL, '1), 1'b0);
        queue_request(csr_access(KIND_SET, CSR_VTYPE, '1), 1'b0);
        queue_request(csr_access(KIND_WRITE, CSR_VLENB, '0), 1'b0);
        queue_request(csr_access(KIND_CLEAR, CSR_CYCLE, '1), 1'b0);
        queue_request(csr_access(KIND_WRITE, CSR_INSTRET, '0), 1'b0);
        queue_request(csr_access(KIND_SET, CSR_MHARTID, '1), 1'b0);
        // AVL selection: rs1 register, keep vl, all ones, immediate
        queue_request(vset(OP_VSETVLI, '1, 1'b0, 1'b0, 64'h03), 1'b0);
        queue_request(vset(OP_VSETVLI, rand64(), 1'b1, 1'b1, 64'h18), 1'b0);
        queue_request(vset(OP_VSETVL, rand64(), 1'b1, 1'b0, 64'hc9), 1'b0);
        queue_request(vset(OP_VSETIVLI, 64'd0, 1'b1, 1'b1, 64'h1b), 1'b0);
        // illegal vtype: high bit, reserved lmul, reserved sew; vill then reads back
        queue_request(vset(OP_VSETVL, 64'd3, 1'b0, 1'b0, VILL_MARK), 1'b0);
        queue_request(csr_access(KIND_READ, CSR_VTYPE, '0), 1'b0);
        queue_request(vset(OP_VSETVLI, 64'd7, 1'b0, 1'b0, 64'h04), 1'b0);
        queue_request(vset(OP_VSETIVLI, 64'd9, 1'b0, 1'b1, 64'h20), 1'b0);
        wait_drained();

        // Random phases, each under its own hart id
        foreach (hart_ids[p])
        begin
            write_hart_id(hart_ids[p]);
            for (int i = 0; i < 300; i++)
                queue_request(random_request(), i == 120);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (due_responses.size() != 0)
            report_mismatch("responses still outstanding at end, count",
                            64'(due_responses.size()), '0);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/vcsr_pkg.sv
hdl/vcsr_store.sv
hdl/vcsr_exec.sv
hdl/vector_config_and_csr_unit.sv
tb/tb_vector_config_and_csr_unit.sv
